/* rtl/qdsc_pkg.sv */
// Shared types, register indexes and the quadrature transition table
// for the detent step counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdsc_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_CONSUME = 2'd1,
    FUNC_DISCARD = 2'd2,
    FUNC_PRIME   = 2'd3
  } func_t;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  localparam int PADDR_W = 3;

  localparam logic [3:0] THRESHOLD_RESET = 4'd2;
  localparam logic [6:0] LIMIT_RESET     = 7'd20;

  // Half-step move for a change from prev to cur (A in bit 1, B in bit 0)
  function automatic logic signed [1:0] quad_move(input logic [1:0] prev,
                                                  input logic [1:0] cur);
    logic signed [1:0] mv;
    begin
      case ({prev, cur})
        4'd1, 4'd7, 4'd8, 4'd14: mv = -2'sd1;
        4'd2, 4'd4, 4'd11, 4'd13: mv = 2'sd1;
        default: mv = 2'sd0;
      endcase
      return mv;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/quadrature_detent_step_counter.sv */
// Quadrature detent step counter: top level with request register,
// single-pass update logic, result register and APB-style registers.
// Depends on qdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | handshake            | payload
// ----------+----------------------+----------------------------------------
// request   | in_valid / in_ready  | func[1:0], pin_a, pin_b
// result    | out_valid / out_ready| step[1:0] s, pending_count[7:0] s,
//           |                      | step_pending
// config    | psel/penable/pwrite  | paddr[2:0], pwdata/prdata[31:0], pready
//
// One request per clock while the result is not stalled: a request lands in
// the request register, is decoded against the counter state in one pass
// and its result is held in the result register. The request register
// takes a request while a result waits only when it is empty; a stalled
// result then holds both stages. Reset (rst, synchronous) clears the
// counter state and loads the register defaults; no clearing pass needed.
module quadrature_detent_step_counter
  import qdsc_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  // request channel
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [1:0]                func,
  input  wire                       pin_a,
  input  wire                       pin_b,
  // result channel
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [1:0]         step,
  output logic signed [7:0]         pending_count,
  output logic                      step_pending,
  // configuration port
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [PADDR_W-1:0]        paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Configuration registers
  logic [3:0] detent_threshold;
  logic [6:0] pending_limit;

  // Request register
  logic       req_valid;
  func_t      req_func;
  logic [1:0] req_ab;

  // Counter state
  logic [1:0]        previous_ab,     previous_ab_next;
  logic signed [4:0] half_step_accum, half_step_accum_next;
  logic signed [7:0] queued_detents,  queued_detents_next;
  logic              pending_flag,    pending_flag_next;
  logic signed [1:0] step_next;

  logic advance;
  logic cfg_write;

  // Register index is the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_threshold <= THRESHOLD_RESET;
      pending_limit    <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_THRESHOLD: detent_threshold <= pwdata[3:0];
        REG_LIMIT:     pending_limit    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = {28'd0, detent_threshold};
      REG_LIMIT:     prdata = {25'd0, pending_limit};
      default:       prdata = 32'd0;
    endcase
  end

  // Move the held request forward when the result register is free or
  // being emptied this cycle.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_func <= func_t'(func);
      req_ab   <= {pin_a, pin_b};
    end
  end

  // Single-pass update of the counter state for the held request
  always_comb begin
    logic [3:0]        thr;
    logic signed [5:0] thr_s;
    logic signed [5:0] sum;
    logic signed [7:0] lim_s;
    logic signed [1:0] mv;

    previous_ab_next     = previous_ab;
    half_step_accum_next = half_step_accum;
    queued_detents_next  = queued_detents;
    pending_flag_next    = pending_flag;
    step_next            = 2'sd0;

    // A zero threshold counts as one
    thr   = (detent_threshold == 4'd0) ? 4'd1 : detent_threshold;
    thr_s = $signed({2'b00, thr});
    lim_s = $signed({1'b0, pending_limit});
    mv    = quad_move(previous_ab, req_ab);
    sum   = $signed({half_step_accum[4], half_step_accum}) + 6'(mv);

    case (req_func)
      FUNC_SAMPLE: begin
        if (req_ab != previous_ab) begin
          previous_ab_next = req_ab;
          // Double changes move nothing
          if (mv != 2'sd0) begin
            if (sum >= thr_s) begin
              pending_flag_next = 1'b1;
              if (queued_detents < lim_s) begin
                queued_detents_next = queued_detents + 8'sd1;
              end
              half_step_accum_next = 5'(sum - thr_s);
            end else if (sum <= -thr_s) begin
              pending_flag_next = 1'b1;
              if (queued_detents > -lim_s) begin
                queued_detents_next = queued_detents - 8'sd1;
              end
              half_step_accum_next = 5'(sum + thr_s);
            end else begin
              half_step_accum_next = 5'(sum);
            end
          end
        end
      end
      FUNC_CONSUME: begin
        if (queued_detents > 8'sd0) begin
          step_next           = 2'sd1;
          queued_detents_next = queued_detents - 8'sd1;
        end else if (queued_detents < 8'sd0) begin
          step_next           = -2'sd1;
          queued_detents_next = queued_detents + 8'sd1;
        end
        pending_flag_next = (queued_detents_next != 8'sd0);
      end
      FUNC_DISCARD: begin
        pending_flag_next    = 1'b0;
        queued_detents_next  = 8'sd0;
        half_step_accum_next = 5'sd0;
      end
      default: begin
        // Prime: load the previous state only
        previous_ab_next = req_ab;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab     <= 2'd0;
      half_step_accum <= 5'sd0;
      queued_detents  <= 8'sd0;
      pending_flag    <= 1'b0;
    end else if (advance) begin
      previous_ab     <= previous_ab_next;
      half_step_accum <= half_step_accum_next;
      queued_detents  <= queued_detents_next;
      pending_flag    <= pending_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step          <= step_next;
      pending_count <= queued_detents_next;
      step_pending  <= pending_flag_next;
    end
  end

endmodule

`default_nettype wire
